>>> rtl/core/cfrp_pkg.sv
// Shared types and constants for the capture file rotation policy block.
package cfrp_pkg;

	localparam int unsigned ACC_BITS    = 40;
	localparam int unsigned BYTES_W     = 32;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned MB_W        = 16;
	localparam int unsigned SLOT_W      = 16;
	localparam int unsigned TOTAL_W     = 32;
	localparam int unsigned MIB_SHIFT   = 20;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned IN_DATA_W   = 64;
	localparam int unsigned OUT_DATA_W  = 24;

	typedef enum logic [1:0] {
		DEC_SAME = 2'd0,
		DEC_NEW  = 2'd1,
		DEC_QUIT = 2'd2
	} decision_t;

	typedef enum logic [1:0] {
		WHY_NONE  = 2'd0,
		WHY_TIME  = 2'd1,
		WHY_SIZE  = 2'd2,
		WHY_LIMIT = 2'd3
	} reason_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROLLOVER_MB = 2'd0,
		REG_DURATION    = 2'd1,
		REG_FILE_LIMIT  = 2'd2,
		REG_RING_MODE   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [MB_W-1:0]   rollover_megabytes;
		logic [TIME_W-1:0] duration_seconds;
		logic [SLOT_W-1:0] file_limit;
		logic              ring_mode;
	} cfg_t;

	typedef struct packed {
		logic [ACC_BITS-1:0] byte_accumulator;
		logic                timer_started;
		logic [TIME_W-1:0]   period_start_time;
		logic [SLOT_W-1:0]   current_slot;
		logic [TOTAL_W-1:0]  files_total;
	} policy_state_t;

	typedef struct packed {
		decision_t         decision;
		reason_t           reason;
		logic [SLOT_W-1:0] slot_index;
	} result_t;

endpackage

>>> rtl/core/cfrp_decide.sv
// Single-pass rotation decision: next policy state and result for one write.
module cfrp_decide
	import cfrp_pkg::*;
(
	input  cfg_t                cfg,
	input  policy_state_t       cur,
	input  logic [BYTES_W-1:0]  write_bytes,
	input  logic [TIME_W-1:0]   now_seconds,
	output policy_state_t       nxt,
	output result_t             res
);

	logic [ACC_BITS:0]   sum;
	logic [ACC_BITS-1:0] acc_sat;
	logic [ACC_BITS-1:0] size_limit;
	logic [TIME_W-1:0]   start_eff;
	logic [TIME_W-1:0]   elapsed;
	logic                time_on;
	logic                time_hit;
	logic                size_hit;
	logic                roll;
	logic                limit_on;
	logic                quit;
	logic [SLOT_W-1:0]   slot_base;
	logic [SLOT_W-1:0]   slot_pick;

	always_comb begin
		sum     = {1'b0, cur.byte_accumulator} + {{(ACC_BITS + 1 - BYTES_W){1'b0}}, write_bytes};
		acc_sat = sum[ACC_BITS] ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];

		time_on   = (cfg.duration_seconds != '0);
		start_eff = cur.timer_started ? cur.period_start_time : now_seconds;
		elapsed   = now_seconds - start_eff;
		time_hit  = time_on && (elapsed >= cfg.duration_seconds);

		// Megabyte limit is exact: 16-bit count shifted by 20 fits the accumulator.
		size_limit = {{(ACC_BITS - MB_W - MIB_SHIFT){1'b0}}, cfg.rollover_megabytes,
			{MIB_SHIFT{1'b0}}};
		size_hit   = !time_hit && (cfg.rollover_megabytes != '0) && (acc_sat > size_limit);
		roll       = time_hit || size_hit;

		limit_on  = (cfg.file_limit != '0);
		slot_base = time_hit ? '0 : cur.current_slot;
		quit      = limit_on && !cfg.ring_mode &&
			(cur.files_total >= {{(TOTAL_W - SLOT_W){1'b0}}, cfg.file_limit});
		slot_pick = (limit_on && (slot_base >= cfg.file_limit)) ? '0 : slot_base;

		nxt                   = cur;
		nxt.byte_accumulator  = roll ? {{(ACC_BITS - BYTES_W){1'b0}}, write_bytes} : acc_sat;
		nxt.timer_started     = cur.timer_started || time_on;
		nxt.period_start_time = time_on ? (time_hit ? now_seconds : start_eff)
			: cur.period_start_time;
		nxt.current_slot      = slot_base;

		res.decision   = DEC_SAME;
		res.reason     = WHY_NONE;
		res.slot_index = '0;

		if (roll) begin
			res.reason = time_hit ? WHY_TIME : WHY_SIZE;
			if (quit) begin
				res.decision = DEC_QUIT;
				res.reason   = WHY_LIMIT;
			end else begin
				res.decision     = DEC_NEW;
				res.slot_index   = slot_pick;
				nxt.current_slot = slot_pick + SLOT_W'(1);
				if (cur.files_total != {TOTAL_W{1'b1}}) begin
					nxt.files_total = cur.files_total + TOTAL_W'(1);
				end
			end
		end
	end

endmodule

>>> rtl/core/capture_file_rotation_policy.sv
// Capture file rotation policy: one keep, new-file or quit decision per write beat.
// Pipeline: input stage register, then result register, before a result beat is valid.
// Throughput: one beat per cycle unless m_tready stalls the output; the policy state
// loops back through adders and compares.
// Reset: arst_n clears configuration, policy state and both stage valids at once.
module capture_file_rotation_policy
	import cfrp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // [31:0] write_bytes, [63:32] now_seconds
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata    // [1:0] decision, [3:2] reason, [19:4] slot_index
);

	// Configuration registers. The first accepted beat locks them until the
	// next reset, so later writes are simply dropped.
	cfg_t cfg_q;
	logic locked_q;

	// Input stage: holds one write beat while the decision is formed.
	logic               valid_s1;
	logic [BYTES_W-1:0] bytes_s1;
	logic [TIME_W-1:0]  now_s1;

	// Policy state and the registered result beat.
	policy_state_t state_q;
	policy_state_t state_nxt;
	result_t       res_nxt;
	result_t       res_q;
	logic          out_valid_q;

	logic advance;
	logic in_take;

	// The result register frees whenever the consumer takes its beat, so the
	// input stage moves on in the same cycle; no bubble between beats.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	cfrp_decide u_decide (
		.cfg         (cfg_q),
		.cur         (state_q),
		.write_bytes (bytes_s1),
		.now_seconds (now_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			locked_q <= 1'b0;
		end else begin
			if (in_take) begin
				locked_q <= 1'b1;
			end
			if (cfg_we && !locked_q) begin
				unique case (reg_index_t'(cfg_index))
					REG_ROLLOVER_MB: cfg_q.rollover_megabytes <= cfg_wdata[MB_W-1:0];
					REG_DURATION:    cfg_q.duration_seconds   <= cfg_wdata[TIME_W-1:0];
					REG_FILE_LIMIT:  cfg_q.file_limit         <= cfg_wdata[SLOT_W-1:0];
					REG_RING_MODE:   cfg_q.ring_mode          <= cfg_wdata[0];
					default:         cfg_q                    <= cfg_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			bytes_s1 <= s_tdata[BYTES_W-1:0];
			now_s1   <= s_tdata[BYTES_W+TIME_W-1:BYTES_W];
		end
	end

	// The state only moves when a staged beat is turned into a result, which
	// keeps the decisions in beat order whatever the stalls downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - SLOT_W - 4){1'b0}}, res_q.slot_index,
		res_q.reason, res_q.decision};

endmodule

>>> tb/rotation_decision_checker.sv
`timescale 1ns / 100ps
// Checker that predicts every rotation decision and compares it with the result beats.
module rotation_decision_checker
	import cfrp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // [31:0] write_bytes, [63:32] now_seconds
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_DATA_W-1:0]  m_tdata,   // [1:0] decision, [3:2] reason, [19:4] slot_index
	output int                     fail_count,
	output int                     pending_count,
	output int                     new_file_count,
	output int                     time_roll_count,
	output int                     size_roll_count,
	output int                     quit_count
);

	cfg_t                policy_cfg;
	logic                cfg_frozen;
	logic [ACC_BITS-1:0] file_bytes;
	logic                timer_on;
	logic [TIME_W-1:0]   period_t0;
	logic [SLOT_W-1:0]   next_slot;
	logic [TOTAL_W-1:0]  total_files;
	result_t             expected_decisions[$];
	int                  errors;
	int                  n_new;
	int                  n_time;
	int                  n_size;
	int                  n_quit;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("%t mismatch in %s: got 0x%0h, predicted 0x%0h", $realtime, what, got, want);
	endtask

	// Advances the policy state by one write beat and returns the decision it causes.
	function automatic result_t decide_rotation(input logic [BYTES_W-1:0] nbytes,
			input logic [TIME_W-1:0] now_s);
		logic [ACC_BITS-1:0] full_acc;
		logic [ACC_BITS-1:0] wide_bytes;
		logic [TIME_W-1:0]   elapsed;
		logic [63:0]         size_limit;
		logic                rolled;
		result_t             r;
		full_acc = '1;
		wide_bytes = ACC_BITS'(nbytes);
		r.decision = DEC_SAME;
		r.reason = WHY_NONE;
		r.slot_index = '0;
		rolled = 1'b0;
		file_bytes = (file_bytes > full_acc - wide_bytes) ? full_acc : file_bytes + wide_bytes;
		if (policy_cfg.duration_seconds != '0) begin
			if (!timer_on) begin
				period_t0 = now_s;
				timer_on = 1'b1;
			end
			elapsed = now_s - period_t0;
			if (elapsed >= policy_cfg.duration_seconds) begin
				period_t0 = now_s;
				next_slot = '0;
				file_bytes = wide_bytes;
				r.reason = WHY_TIME;
				rolled = 1'b1;
			end
		end
		if (!rolled && policy_cfg.rollover_megabytes != '0) begin
			size_limit = 64'(policy_cfg.rollover_megabytes) << MIB_SHIFT;
			if (64'(file_bytes) > size_limit) begin
				file_bytes = wide_bytes;
				r.reason = WHY_SIZE;
				rolled = 1'b1;
			end
		end
		if (rolled) begin
			if (policy_cfg.file_limit != '0 && !policy_cfg.ring_mode
					&& total_files >= TOTAL_W'(policy_cfg.file_limit)) begin
				r.decision = DEC_QUIT;
				r.reason = WHY_LIMIT;
			end else begin
				if (policy_cfg.file_limit != '0 && next_slot >= policy_cfg.file_limit)
					next_slot = '0;
				r.decision = DEC_NEW;
				r.slot_index = next_slot;
				if (total_files != '1)
					total_files++;
				next_slot++;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			policy_cfg = '0;
			cfg_frozen = 1'b0;
			file_bytes = '0;
			timer_on = 1'b0;
			period_t0 = '0;
			next_slot = '0;
			total_files = '0;
			expected_decisions.delete();
			errors = 0;
			n_new = 0;
			n_time = 0;
			n_size = 0;
			n_quit = 0;
		end else begin
			// Registers only take writes until the first write beat after reset.
			if (cfg_we && !cfg_frozen) begin
				case (reg_index_t'(cfg_index))
					REG_ROLLOVER_MB: policy_cfg.rollover_megabytes = cfg_wdata[MB_W-1:0];
					REG_DURATION:    policy_cfg.duration_seconds = cfg_wdata[TIME_W-1:0];
					REG_FILE_LIMIT:  policy_cfg.file_limit = cfg_wdata[SLOT_W-1:0];
					REG_RING_MODE:   policy_cfg.ring_mode = cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				cfg_frozen = 1'b1;
				expected_decisions.push_back(
					decide_rotation(s_tdata[BYTES_W-1:0], s_tdata[BYTES_W +: TIME_W]));
			end
			if (m_tvalid && m_tready) begin
				if (expected_decisions.size() == 0) begin
					report_mismatch("result beat with nothing outstanding", 32'(m_tdata), '0);
				end else begin
					want = expected_decisions.pop_front();
					if (m_tdata[1:0] !== want.decision)
						report_mismatch("decision", 32'(m_tdata[1:0]), 32'(want.decision));
					if (m_tdata[3:2] !== want.reason)
						report_mismatch("reason", 32'(m_tdata[3:2]), 32'(want.reason));
					if (m_tdata[19:4] !== want.slot_index)
						report_mismatch("slot_index", 32'(m_tdata[19:4]),
							32'(want.slot_index));
					if (m_tdata[OUT_DATA_W-1:20] !== '0)
						report_mismatch("tdata padding", 32'(m_tdata[OUT_DATA_W-1:20]), '0);
					if (want.decision == DEC_NEW) begin
						n_new++;
						if (want.reason == WHY_TIME)
							n_time++;
						else
							n_size++;
					end else if (want.decision == DEC_QUIT) begin
						n_quit++;
					end
				end
			end
		end
		fail_count <= errors;
		pending_count <= expected_decisions.size();
		new_file_count <= n_new;
		time_roll_count <= n_time;
		size_roll_count <= n_size;
		quit_count <= n_quit;
	end

endmodule

>>> tb/capture_file_rotation_policy_test.sv
`timescale 1ns / 100ps
// Top of the rotation policy testbench: clock, reset, write-beat stimulus and the verdict.
module capture_file_rotation_policy_test;
	import cfrp_pkg::*;

	localparam int unsigned HALF_PERIOD  = 5;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned PHASE_ITEMS  = 800;
	localparam int unsigned CALM_ITEMS   = 150;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;    // [31:0] write_bytes, [63:32] now_seconds
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;         // [1:0] decision, [3:2] reason, [19:4] slot_index

	int          fail_count;
	int          pending_count;
	int          new_file_count;
	int          time_roll_count;
	int          size_roll_count;
	int          quit_count;
	int unsigned cycle_count = 0;
	int unsigned beats_sent = 0;

	// Whether the sender and the receiver are currently allowed to idle.
	bit                send_idling = 1'b1;
	bit                take_idling = 1'b1;
	// The one policy that this run uses: the registers freeze at the first write beat,
	// and reset is only applied once, so each seed picks its own policy up front.
	cfg_t              chosen;
	// Running wall clock handed to the block with each write beat.
	logic [TIME_W-1:0] clock_now;

	capture_file_rotation_policy i_dut (.*);

	rotation_decision_checker i_checker (.*);

	always #(HALF_PERIOD) clk = ~clk;

	// Watchdog: a hung handshake must not stall the run forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("%t watchdog expired after %0d cycles", $realtime, LIMIT_CYCLES);
			$display("status: fail");
			$finish;
		end
	end

	// Result side: ready is dropped in random bursts while idling is on.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (take_idling && $urandom_range(0, 99) < 12) begin
				stall_left = $urandom_range(1, 16) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// One register write; the enable is lowered again before the next write raises it, so
	// it never gets two assignments in one time step.
	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one write beat and returns at the edge that accepts it, with tvalid still
	// high so that a following beat can go out without a bubble.
	task automatic push_write(input logic [BYTES_W-1:0] nbytes, input logic [TIME_W-1:0] now_s);
		if (send_idling && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now_s, nbytes};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// Lowers tvalid and waits until every predicted decision has come back, then lets
	// the two-stage pipeline settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);
	endtask

	// Chooses the policy for this seed. Most runs get small files, short periods and a
	// handful of slots so that every kind of decision turns up; the others take the
	// register extremes, a one-second period, or everything switched off.
	task automatic pick_policy();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		chosen.ring_mode = ($urandom_range(0, 3) != 0);
		if (pick < 65) begin
			chosen.rollover_megabytes = MB_W'($urandom_range(1, 3));
			chosen.duration_seconds = $urandom_range(20, 200);
			chosen.file_limit = SLOT_W'($urandom_range(1, 6));
			if (pick >= 50)
				chosen.ring_mode = 1'b0;
		end else if (pick < 80) begin
			chosen.rollover_megabytes = '1;
			chosen.duration_seconds = '1;
			chosen.file_limit = '1;
		end else if (pick < 90) begin
			chosen.rollover_megabytes = MB_W'($urandom_range(1, 65535));
			chosen.duration_seconds = 32'd1;
			chosen.file_limit = '0;
		end else begin
			chosen.rollover_megabytes = '0;
			chosen.duration_seconds = '0;
			chosen.file_limit = '0;
		end
	endtask

	// Writes after the first beat must leave the policy untouched, so these only
	// check that the block really keeps its registers frozen.
	task automatic rewrite_frozen_regs(input bit extremes);
		write_reg(REG_ROLLOVER_MB, extremes ? '0 : $urandom());
		write_reg(REG_DURATION, extremes ? '1 : $urandom());
		write_reg(REG_FILE_LIMIT, extremes ? '0 : $urandom());
		write_reg(REG_RING_MODE, extremes ? '1 : $urandom());
	endtask

	// A random write beat. Time often stays put or creeps forward by amounts scaled
	// to the period, with exact boundary steps, a step backwards and occasional jumps
	// anywhere; the byte count is mostly a fraction of the file size so that files fill
	// over a few beats, mixed with empty, full-scale and fully random counts.
	task automatic random_write();
		logic [63:0]        size_hint;
		logic [31:0]        cap;
		logic [31:0]        span;
		logic [BYTES_W-1:0] nbytes;
		int unsigned        roll;
		span = (chosen.duration_seconds == '0 || chosen.duration_seconds > 1000)
			? 32'd1000 : chosen.duration_seconds;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			clock_now = clock_now;
		else if (roll < 65)
			clock_now += $urandom_range(1, span / 4 + 1);
		else if (roll < 80)
			clock_now += $urandom_range(span - 1, span + 1);
		else if (roll < 85)
			clock_now -= 1;
		else
			clock_now = $urandom();
		size_hint = (chosen.rollover_megabytes == '0) ? 64'h10_0000
			: 64'(chosen.rollover_megabytes) << MIB_SHIFT;
		cap = (size_hint / 3 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(size_hint / 3);
		roll = $urandom_range(0, 99);
		if (roll < 8)
			nbytes = '0;
		else if (roll < 16)
			nbytes = '1;
		else if (roll < 36)
			nbytes = $urandom();
		else
			nbytes = $urandom_range(cap, 0);
		push_write(nbytes, clock_now);
	endtask

	// A phase of random beats; every hundred beats each side decides afresh whether
	// it idles, which leaves stretches of full-rate traffic in between.
	task automatic random_phase(input int unsigned count);
		for (int unsigned k = 0; k < count; k++) begin
			if (k % 100 == 0) begin
				send_idling = ($urandom_range(0, 9) < 7);
				take_idling = ($urandom_range(0, 9) < 7);
			end
			random_write();
		end
	endtask

	initial begin
		pick_policy();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Every register first sees its largest value, then the policy for this run.
		write_reg(REG_ROLLOVER_MB, 32'h0000_FFFF);
		write_reg(REG_DURATION, '1);
		write_reg(REG_FILE_LIMIT, 32'h0000_FFFF);
		write_reg(REG_RING_MODE, '1);
		write_reg(REG_ROLLOVER_MB, CFG_DATA_W'(chosen.rollover_megabytes));
		write_reg(REG_DURATION, chosen.duration_seconds);
		write_reg(REG_FILE_LIMIT, CFG_DATA_W'(chosen.file_limit));
		write_reg(REG_RING_MODE, CFG_DATA_W'(chosen.ring_mode));

		// Directed beats. The period timer starts on a zero time stamp, then full-scale
		// counts push the byte total up, the period is hit exactly and just passed,
		// the wall clock wraps (which also ends a period of the largest length, since
		// it started at zero), and a run of full-scale counts at a fixed time overflows
		// even the largest file size.
		push_write('0, '0);
		push_write('1, 32'd1);
		push_write('1, 32'd1);
		push_write(32'h0010_0000, chosen.duration_seconds);
		push_write(32'h0010_0001, chosen.duration_seconds + 1);
		push_write(32'd1, 32'hFFFF_FFFF);
		push_write('0, 32'd3);
		repeat (17) push_write('1, 32'd3);
		clock_now = 32'd3;
		wait_drained();

		rewrite_frozen_regs(1'b0);
		random_phase(PHASE_ITEMS);
		wait_drained();

		rewrite_frozen_regs(1'b1);
		random_phase(PHASE_ITEMS);

		// Closing stretch at full rate on both sides.
		send_idling = 1'b0;
		take_idling = 1'b0;
		for (int unsigned k = 0; k < CALM_ITEMS; k++)
			random_write();
		wait_drained();

		$display("Sent %0d write beats under a policy of %0d MiB files, %0d s periods,",
			beats_sent, chosen.rollover_megabytes, chosen.duration_seconds);
		$display("%0d slots, ring %0b; %0d new files (%0d on time, %0d on size), %0d quits.",
			chosen.file_limit, chosen.ring_mode, new_file_count, time_roll_count,
			size_roll_count, quit_count);
		if (fail_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
